// ===== design/shell_command_line_tokenizer_assert.svh =====
// Assertion macros used by the tokenizer top level.
`ifndef SHELL_COMMAND_LINE_TOKENIZER_ASSERT_SVH
`define SHELL_COMMAND_LINE_TOKENIZER_ASSERT_SVH

`ifndef SYNTHESIS

// Checks a property at every rising clock edge outside reset.
`define SCTOK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition never holds at a rising clock edge outside reset.
`define SCTOK_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`else

`define SCTOK_ASSERT(lbl, prop, msg)
`define SCTOK_ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

// ===== design/sctok_pkg.sv =====
// Types, constants and character codes shared by the tokenizer modules.
package sctok_pkg;

  // Saturation point of the character position and the bracket depth limit.
  localparam int unsigned MaxLineLength = 65535;
  localparam int unsigned MaxDepth      = 255;

  localparam int unsigned PosW      = $clog2(MaxLineLength + 1);
  localparam int unsigned DepthW    = $clog2(MaxDepth + 1);
  localparam int unsigned CharW     = 8;
  localparam int unsigned TokStartW = 16;

  // Item kinds carried in the input tuser bit.
  localparam logic ModeChar = 1'b0;
  localparam logic ModeEol  = 1'b1;

  // Character codes with a special meaning.
  localparam logic [CharW-1:0] ChNewline = 8'h0A;
  localparam logic [CharW-1:0] ChTab     = 8'h09;
  localparam logic [CharW-1:0] ChSpace   = 8'h20;
  localparam logic [CharW-1:0] ChSemi    = 8'h3B;
  localparam logic [CharW-1:0] ChDquote  = 8'h22;
  localparam logic [CharW-1:0] ChSquote  = 8'h27;
  localparam logic [CharW-1:0] ChOpen    = 8'h28;
  localparam logic [CharW-1:0] ChClose   = 8'h29;

  // Tokenizer state carried from one character to the next.
  typedef struct packed {
    logic [DepthW-1:0] depth;
    logic              in_dquote;
    logic              in_squote;
    logic              token_pending;
    logic              command_pending;
    logic [PosW-1:0]   start_pos;
    logic [PosW-1:0]   char_pos;
    logic              failed;
  } state_t;

  // One result beat.
  typedef struct packed {
    logic                 error;
    logic                 line_end;
    logic                 command_done;
    logic [TokStartW-1:0] token_start;
    logic                 token_done;
    logic [CharW-1:0]     append_char;
    logic                 append_valid;
  } result_t;

endpackage

// ===== design/sctok_step.sv =====
// Next-state and result logic for one tokenizer item.
module sctok_step (
  input  sctok_pkg::state_t               state_i,
  input  logic                            mode_i,
  input  logic [sctok_pkg::CharW-1:0]     char_i,
  output sctok_pkg::state_t               state_o,
  output sctok_pkg::result_t              result_o
);

  logic                          nested;
  logic                          app;
  logic                          sep;
  logic [sctok_pkg::PosW-1:0]    new_start;

  // Position after this character, held at the saturation point.
  assign new_start = (state_i.char_pos == sctok_pkg::PosW'(sctok_pkg::MaxLineLength)) ?
                     state_i.char_pos : state_i.char_pos + sctok_pkg::PosW'(1);

  assign nested = (state_i.depth != '0) || state_i.in_dquote || state_i.in_squote;

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    app      = 1'b0;
    sep      = 1'b0;
    if (mode_i == sctok_pkg::ModeEol) begin
      // End of line flushes the pending token and command, then clears everything.
      result_o.line_end = 1'b1;
      if (!state_i.failed) begin
        if (state_i.token_pending) begin
          result_o.token_done  = 1'b1;
          result_o.token_start = sctok_pkg::TokStartW'(state_i.start_pos);
        end
        result_o.command_done = state_i.command_pending || state_i.token_pending;
      end
      result_o.error = state_i.failed;
      state_o        = '0;
    end else if (!state_i.failed) begin
      unique case (char_i)
        sctok_pkg::ChNewline, sctok_pkg::ChSemi: begin
          if (nested) begin
            app = 1'b1;
          end else if (state_i.token_pending || state_i.command_pending) begin
            if (state_i.token_pending) begin
              result_o.token_done  = 1'b1;
              result_o.token_start = sctok_pkg::TokStartW'(state_i.start_pos);
              state_o.token_pending = 1'b0;
            end
            result_o.command_done   = 1'b1;
            state_o.command_pending = 1'b0;
            state_o.start_pos       = new_start;
          end
        end
        sctok_pkg::ChSpace, sctok_pkg::ChTab: begin
          if (nested) begin
            app = 1'b1;
          end else begin
            if (state_i.token_pending) begin
              result_o.token_done     = 1'b1;
              result_o.token_start    = sctok_pkg::TokStartW'(state_i.start_pos);
              state_o.token_pending   = 1'b0;
              state_o.command_pending = 1'b1;
            end
            state_o.start_pos = new_start;
          end
        end
        sctok_pkg::ChDquote: begin
          if (!state_i.in_squote) begin
            state_o.in_dquote = !state_i.in_dquote;
          end
          app = (state_i.depth != '0) || state_i.in_squote;
        end
        sctok_pkg::ChSquote: begin
          if (!state_i.in_dquote) begin
            state_o.in_squote = !state_i.in_squote;
          end
          app = (state_i.depth != '0) || state_i.in_dquote;
        end
        sctok_pkg::ChOpen: begin
          if (state_i.depth == sctok_pkg::DepthW'(sctok_pkg::MaxDepth)) begin
            state_o.failed = 1'b1;
            sep            = 1'b1;
          end else begin
            state_o.depth = state_i.depth + sctok_pkg::DepthW'(1);
            app           = 1'b1;
          end
        end
        sctok_pkg::ChClose: begin
          if (state_i.depth == '0) begin
            state_o.failed = 1'b1;
            sep            = 1'b1;
          end else begin
            state_o.depth = state_i.depth - sctok_pkg::DepthW'(1);
            app           = 1'b1;
          end
        end
        default: begin
          app = 1'b1;
        end
      endcase
      // A failing character neither appends nor advances the position.
      if (!sep) begin
        if (app) begin
          state_o.token_pending = 1'b1;
        end
        state_o.char_pos = new_start;
      end
      result_o.error = state_o.failed;
    end else begin
      // The line has failed: characters are dropped until end of line.
      result_o.error = 1'b1;
    end
    result_o.append_valid = app;
    result_o.append_char  = app ? char_i : '0;
  end

endmodule

// ===== design/shell_command_line_tokenizer.sv =====
// Top level of the shell command line tokenizer with its stream ports.
//
//   Channel  Dir  tdata                           tuser / tlast
//   s_axis   in   [7:0] char_code                 tuser[0] mode
//   m_axis   out  [7:0] append_char,              tuser[0] append_valid, [1] token_done,
//                 [23:8] token_start              [2] command_done, [3] error; tlast line_end
//
// One beat per cycle in both directions unless the output stalls; each input beat yields one output beat.
// Each beat passes an input register, then the tokenizer state update, which
// loads the output register in the same cycle as it updates the state.
// rst_ni clears the tokenizer state and both stage valids asynchronously.
// A stalled output holds its beat; the input register still takes a new beat
// whenever the output register is free or being drained that cycle.
`include "shell_command_line_tokenizer_assert.svh"

module shell_command_line_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tuser,   // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] append_char, [23:8] token_start
  output logic [3:0]  m_axis_tuser,   // [0] append_valid, [1] token_done,
                                      // [2] command_done, [3] error
  output logic        m_axis_tlast    // line_end
);

  logic                          in_valid_q;
  logic                          in_mode_q;
  logic [sctok_pkg::CharW-1:0]   in_char_q;
  logic                          out_valid_q;
  sctok_pkg::result_t            out_res_q;
  sctok_pkg::result_t            res_d;
  sctok_pkg::state_t             st_q;
  sctok_pkg::state_t             st_d;
  logic                          advance;
  logic                          in_accept;

  // The buffered item moves on when the output register is empty or drained.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  sctok_step u_step (
    .state_i  (st_q),
    .mode_i   (in_mode_q),
    .char_i   (in_char_q),
    .state_o  (st_d),
    .result_o (res_d)
  );

  // Stage valids and tokenizer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        st_q        <= st_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_mode_q <= s_axis_tuser;
      in_char_q <= s_axis_tdata;
    end
    if (advance) begin
      out_res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_res_q.token_start, out_res_q.append_char};
  assign m_axis_tuser  = {out_res_q.error, out_res_q.command_done,
                          out_res_q.token_done, out_res_q.append_valid};
  assign m_axis_tlast  = out_res_q.line_end;

  // An end of line item leaves the tokenizer in its reset state.
  `SCTOK_ASSERT(a_eol_clears, advance && (in_mode_q == sctok_pkg::ModeEol) |=> (st_q == '0), "state not cleared after end of line")
  // A failed line never appends a character.
  `SCTOK_ASSERT_NEVER(a_fail_no_append, out_valid_q && out_res_q.error && !out_res_q.line_end && out_res_q.append_valid, "append on a failed line")
  // A character that closes a command is never appended to a token.
  `SCTOK_ASSERT_NEVER(a_cmd_no_append, out_valid_q && out_res_q.command_done && out_res_q.append_valid, "append with command close")
  // A buffered item that cannot move on stays buffered.
  `SCTOK_ASSERT(a_in_hold, in_valid_q && !advance |=> in_valid_q, "buffered item lost")

endmodule

// ===== verif/shell_tokenizer_checker.sv =====
// Checker that predicts the tokenizer's result beats and compares them with the output stream.
`timescale 1ns / 1ps

module shell_tokenizer_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tuser,   // [0] mode
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,   // [7:0] append_char, [23:8] token_start
  input  logic [3:0]  m_axis_tuser,   // [0] append_valid, [1] token_done,
                                      // [2] command_done, [3] error
  input  logic        m_axis_tlast,   // line_end
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_o
);

  // Shadow copy of the tokenizer state for the line in progress.
  sctok_pkg::state_t  line_st;
  sctok_pkg::result_t token_events_q[$];

  // Works out the result of one input beat and advances the shadow state.
  function automatic sctok_pkg::result_t tokenize_char(input logic mode,
                                                       input logic [sctok_pkg::CharW-1:0] ch);
    sctok_pkg::result_t         res;
    logic                       nested;
    logic                       appended;
    logic                       rejected;
    logic [sctok_pkg::PosW-1:0] next_start;
    res      = '0;
    appended = 1'b0;
    rejected = 1'b0;
    if (mode == sctok_pkg::ModeEol) begin
      // End of line flushes whatever is open, even inside quotes or brackets.
      res.line_end = 1'b1;
      if (!line_st.failed) begin
        if (line_st.token_pending) begin
          res.token_done      = 1'b1;
          res.token_start     = sctok_pkg::TokStartW'(line_st.start_pos);
          line_st.command_pending = 1'b1;
        end
        res.command_done = line_st.command_pending;
      end
      res.error = line_st.failed;
      line_st   = '0;
    end else if (!line_st.failed) begin
      nested     = (line_st.depth != '0) || line_st.in_dquote || line_st.in_squote;
      next_start = (line_st.char_pos >= sctok_pkg::PosW'(sctok_pkg::MaxLineLength)) ?
                   sctok_pkg::PosW'(sctok_pkg::MaxLineLength) :
                   line_st.char_pos + sctok_pkg::PosW'(1);
      case (ch)
        sctok_pkg::ChNewline, sctok_pkg::ChSemi: begin
          if (nested) begin
            appended = 1'b1;
          end else if (line_st.token_pending || line_st.command_pending) begin
            if (line_st.token_pending) begin
              res.token_done        = 1'b1;
              res.token_start       = sctok_pkg::TokStartW'(line_st.start_pos);
              line_st.token_pending = 1'b0;
            end
            res.command_done        = 1'b1;
            line_st.command_pending = 1'b0;
            line_st.start_pos       = next_start;
          end
        end
        sctok_pkg::ChSpace, sctok_pkg::ChTab: begin
          if (nested) begin
            appended = 1'b1;
          end else begin
            if (line_st.token_pending) begin
              res.token_done          = 1'b1;
              res.token_start         = sctok_pkg::TokStartW'(line_st.start_pos);
              line_st.token_pending   = 1'b0;
              line_st.command_pending = 1'b1;
            end
            line_st.start_pos = next_start;
          end
        end
        sctok_pkg::ChDquote: begin
          if (!line_st.in_squote) line_st.in_dquote = !line_st.in_dquote;
          appended = (line_st.depth != '0) || line_st.in_squote;
        end
        sctok_pkg::ChSquote: begin
          if (!line_st.in_dquote) line_st.in_squote = !line_st.in_squote;
          appended = (line_st.depth != '0) || line_st.in_dquote;
        end
        sctok_pkg::ChOpen: begin
          // Nesting past the limit fails the line.
          if (line_st.depth >= sctok_pkg::DepthW'(sctok_pkg::MaxDepth)) begin
            line_st.failed = 1'b1;
            rejected       = 1'b1;
          end else begin
            line_st.depth = line_st.depth + sctok_pkg::DepthW'(1);
            appended      = 1'b1;
          end
        end
        sctok_pkg::ChClose: begin
          // A close bracket with nothing open fails the line.
          if (line_st.depth == '0) begin
            line_st.failed = 1'b1;
            rejected       = 1'b1;
          end else begin
            line_st.depth = line_st.depth - sctok_pkg::DepthW'(1);
            appended      = 1'b1;
          end
        end
        default: appended = 1'b1;
      endcase
      if (!rejected) begin
        if (appended) line_st.token_pending = 1'b1;
        line_st.char_pos = next_start;
      end
      res.error = line_st.failed;
    end else begin
      // A failed line ignores the rest of its characters.
      res.error = 1'b1;
    end
    res.append_valid = appended;
    res.append_char  = appended ? ch : '0;
    return res;
  endfunction

  // Reports one field that differs from its prediction.
  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      mismatch_cnt_o++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Compare finished result beats, then predict for each accepted input beat.
  always @(posedge clk_i or negedge rst_ni) begin
    sctok_pkg::result_t want;
    sctok_pkg::result_t got;
    if (!rst_ni) begin
      line_st = '0;
      token_events_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.append_valid = m_axis_tuser[0];
        got.token_done   = m_axis_tuser[1];
        got.command_done = m_axis_tuser[2];
        got.error        = m_axis_tuser[3];
        got.line_end     = m_axis_tlast;
        got.append_char  = m_axis_tdata[7:0];
        got.token_start  = m_axis_tdata[23:8];
        if (token_events_q.size() == 0) begin
          mismatch_cnt_o++;
          $display("%0t ns: result beat with none expected, actual %0h", $time, got);
        end else begin
          want = token_events_q.pop_front();
          check_field("append_valid", 32'(want.append_valid), 32'(got.append_valid));
          check_field("append_char", 32'(want.append_char), 32'(got.append_char));
          check_field("token_done", 32'(want.token_done), 32'(got.token_done));
          check_field("token_start", 32'(want.token_start), 32'(got.token_start));
          check_field("command_done", 32'(want.command_done), 32'(got.command_done));
          check_field("line_end", 32'(want.line_end), 32'(got.line_end));
          check_field("error", 32'(want.error), 32'(got.error));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        token_events_q.insert(token_events_q.size(), tokenize_char(s_axis_tuser, s_axis_tdata));
      end
    end
    pending_o = token_events_q.size();
  end

endmodule

// ===== verif/tb_shell_command_line_tokenizer.sv =====
// Testbench top for the shell command line tokenizer: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_shell_command_line_tokenizer;

  localparam int unsigned CycleLimit = 1000000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tuser  = sctok_pkg::ModeChar;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;

  int unsigned mismatch_cnt;
  int unsigned pending_cnt;
  int unsigned beats_sent;
  int unsigned cycle_cnt;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  shell_command_line_tokenizer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  shell_tokenizer_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .m_axis_tlast   (m_axis_tlast),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending_cnt)
  );

  // The receiver stalls at random for the current share of cycles.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog against a hung handshake or results that never arrive.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offers one beat after a random gap and returns at the edge that accepts it.
  task automatic send_beat(input logic mode, input logic [7:0] ch);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= ch;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    beats_sent++;
  endtask

  // Sends a text as character beats, then an end of line beat.
  task automatic send_line(input string text);
    for (int i = 0; i < text.len(); i++) send_beat(sctok_pkg::ModeChar, text[i]);
    send_beat(sctok_pkg::ModeEol, 8'($urandom));
  endtask

  // Random line; a well-formed one never closes a bracket that is not open.
  task automatic send_random_line(input bit well_formed);
    int unsigned len;
    int unsigned depth;
    int unsigned pick;
    logic [7:0]  ch;
    logic        mode;
    len   = $urandom_range(24, 1);
    depth = 0;
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      if (pick < 45)      ch = 8'h61 + 8'($urandom_range(25));
      else if (pick < 52) ch = sctok_pkg::ChSpace;
      else if (pick < 56) ch = sctok_pkg::ChTab;
      else if (pick < 60) ch = sctok_pkg::ChSemi;
      else if (pick < 63) ch = sctok_pkg::ChNewline;
      else if (pick < 70) ch = sctok_pkg::ChDquote;
      else if (pick < 76) ch = sctok_pkg::ChSquote;
      else if (pick < 84) ch = sctok_pkg::ChOpen;
      else if (pick < 91) ch = sctok_pkg::ChClose;
      else                ch = 8'($urandom);
      if (well_formed && ch == sctok_pkg::ChClose && depth == 0) begin
        ch = 8'h61 + 8'($urandom_range(25));
      end
      if (ch == sctok_pkg::ChOpen) depth++;
      else if (ch == sctok_pkg::ChClose && depth > 0) depth--;
      // Broken lines also get stray end of line beats.
      mode = (!well_formed && $urandom_range(9) == 0) ? sctok_pkg::ModeEol
                                                       : sctok_pkg::ModeChar;
      send_beat(mode, ch);
    end
    send_beat(sctok_pkg::ModeEol, 8'($urandom));
  endtask

  task automatic run_random_lines(input int unsigned beats);
    int unsigned stop_at;
    stop_at = beats_sent + beats;
    while (beats_sent < stop_at) send_random_line($urandom_range(99) < 80);
  endtask

  initial begin
    send_idle_pct = 19;
    recv_idle_pct = 45;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed lines: separators, quotes, brackets, an unmatched close,
    // end of line inside an open quote, extreme bytes and an empty line.
    send_line("ab c;");
    send_line("\"a 'b\"'\" \t;");
    send_line("(x\n)y");
    send_line("z)q");
    send_beat(sctok_pkg::ModeChar, 8'h00);
    send_beat(sctok_pkg::ModeChar, 8'hFF);
    send_beat(sctok_pkg::ModeEol, 8'hFF);
    send_beat(sctok_pkg::ModeEol, 8'h00);

    run_random_lines(400);
    send_idle_pct = 45;
    recv_idle_pct = 19;
    run_random_lines(400);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_lines(400);

    // Nesting up to the limit is fine; one level more fails the line.
    repeat (255) send_beat(sctok_pkg::ModeChar, sctok_pkg::ChOpen);
    send_beat(sctok_pkg::ModeChar, sctok_pkg::ChClose);
    send_beat(sctok_pkg::ModeChar, sctok_pkg::ChOpen);
    send_beat(sctok_pkg::ModeChar, sctok_pkg::ChOpen);
    send_beat(sctok_pkg::ModeChar, 8'h78);
    send_beat(sctok_pkg::ModeEol, 8'h00);
    s_axis_tvalid <= 1'b0;

    // Drain the outstanding results, then allow for the pipeline latency.
    @(negedge clk_i);
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/sctok_pkg.sv
design/sctok_step.sv
design/shell_command_line_tokenizer.sv
verif/shell_tokenizer_checker.sv
verif/tb_shell_command_line_tokenizer.sv
